// ===== rtl/core/lenv_pkg.sv =====
// lenv_pkg: shared types, constants and the hash output mapping for the
// linear environment bank. No dependencies.
`default_nettype none
package lenv_pkg;

  localparam int ENV_COUNT_DEF = 64;
  localparam int OBS_DIM_DEF   = 16;
  localparam int ACT_DIM_DEF   = 8;
  localparam int LANES         = 2;
  localparam int MAX_OUT       = 16;
  localparam int OFIFO_DEPTH   = 8;
  localparam int ACC_W         = 25;

  localparam logic [31:0] C_ENV = 32'd73856093;
  localparam logic [31:0] C_DIM = 32'd19349663;
  localparam logic [31:0] C_MIX = 32'd2654435761;

  localparam logic signed [22:0] REWARD_MIN = -23'sd4194304;
  localparam logic [ACC_W-1:0]   COST_MAX   = 25'd4194304;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  localparam logic [1:0] CFG_DECAY = 2'd0;
  localparam logic [1:0] CFG_FORCE = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_STEP_WAIT,
    ST_HASH,
    ST_HASH_WAIT
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] dim;
    logic [5:0] env;
  } step_tag_t;

  typedef struct packed {
    logic fin;
    logic hold;
    logic take;
  } merge_stat_t;

  typedef struct packed {
    logic [5:0]         env;
    logic [3:0]         dim;
    logic signed [15:0] state;
    logic signed [22:0] reward;
    logic               done;
    logic               last;
  } result_t;

  // final mixing step and map of the low 16 bits to about +-0.1
  function automatic logic signed [15:0] hash_map(input logic [31:0] h);
    logic [31:0]        x;
    logic signed [17:0] t;
    logic signed [27:0] p;
    x = h ^ (h >> 16);
    t = $signed({1'b0, x[15:0], 1'b0}) - 18'sd65535;
    p = $signed({{10{t[17]}}, t}) * 28'sd410;
    return 16'(p >>> 16);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lenv_lane.sv =====
// lenv_lane: one lane, its bank of state memory, the step update pipeline
// and the hash pipeline for bulk reset. Depends on lenv_pkg.
`default_nettype none
module lenv_lane #(
  parameter int ENV_COUNT = 64,
  parameter int DPL       = 8,
  parameter int LANE      = 0,
  parameter int AW        = 9
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire lenv_pkg::step_tag_t issue,
  input  wire  [AW-1:0]           rd_addr,
  input  wire  signed [15:0]      act,
  input  wire  signed [15:0]      decay,
  input  wire  signed [15:0]      force_k,
  input  wire                     hash_en,
  input  wire  [AW-1:0]           hash_addr,
  input  wire  [31:0]             seed_env,
  input  wire  [31:0]             grp_mul,
  output lenv_pkg::step_tag_t     res_tag,
  output logic signed [15:0]      res_val
);
  import lenv_pkg::*;

  localparam int          BANK_DEPTH = ENV_COUNT * DPL;
  localparam logic [63:0] LANE_W     = 64'(LANE) * 64'(C_DIM);
  localparam logic [31:0] LANE_C     = LANE_W[31:0];

  logic signed [15:0] mem [BANK_DEPTH];
  logic signed [15:0] rdata_r;

  step_tag_t          tag1_r, tag2_r, tag3_r;
  logic [AW-1:0]      addr1_r, addr2_r;
  logic signed [15:0] act1_r;
  logic signed [31:0] pdec_r, pfrc_r;
  logic signed [32:0] sum;
  logic signed [32:0] shd;
  logic signed [15:0] vsat;
  logic signed [15:0] val3_r;

  logic               ha_v_r, hb_v_r;
  logic [AW-1:0]      ha_addr_r, hb_addr_r;
  logic [31:0]        h0, ha_r, hb_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      ha_v_r <= 1'b0;
      hb_v_r <= 1'b0;
    end else begin
      tag1_r <= issue;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      ha_v_r <= hash_en;
      hb_v_r <= ha_v_r;
    end
  end

  always_ff @(posedge clk) begin
    addr1_r   <= rd_addr;
    act1_r    <= act;
    addr2_r   <= addr1_r;
    pdec_r    <= decay * rdata_r;
    pfrc_r    <= force_k * act1_r;
    val3_r    <= vsat;
    ha_addr_r <= hash_addr;
    ha_r      <= h0 ^ (h0 >> 13);
    hb_addr_r <= ha_addr_r;
    hb_r      <= 32'(ha_r * C_MIX);
  end

  assign h0 = seed_env ^ (grp_mul + LANE_C);

  always_comb begin
    sum = {pdec_r[31], pdec_r} + {pfrc_r[31], pfrc_r};
    shd = sum >>> 12;
    if (shd > 33'sd32767) begin
      vsat = 16'sh7FFF;
    end else if (shd < -33'sd32768) begin
      vsat = -16'sh8000;
    end else begin
      vsat = 16'(shd);
    end
  end

  // hash and step never run together
  always_comb begin
    if (hb_v_r) begin
      wr_en   = 1'b1;
      wr_addr = hb_addr_r;
      wr_data = hash_map(hb_r);
    end else begin
      wr_en   = tag2_r.valid;
      wr_addr = addr2_r;
      wr_data = vsat;
    end
  end

  assign res_tag = tag3_r;
  assign res_val = val3_r;

endmodule
`default_nettype wire

// ===== rtl/core/lenv_merge.sv =====
// lenv_merge: combines the lane results, accumulates the reward, holds the
// last emitted beat until the sum is complete. Depends on lenv_pkg.
`default_nettype none
module lenv_merge #(
  parameter int OBS_DIM = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire lenv_pkg::step_tag_t lane_tag [lenv_pkg::LANES],
  input  wire  signed [15:0]     lane_val [lenv_pkg::LANES],
  input  wire  [14:0]            limit,
  input  wire                    ack_push,
  output logic                   push,
  output lenv_pkg::result_t      push_data,
  output lenv_pkg::merge_stat_t  stat
);
  import lenv_pkg::*;

  localparam int NOUT = (OBS_DIM < MAX_OUT) ? OBS_DIM : MAX_OUT;

  step_tag_t          sel_tag;
  logic signed [15:0] sel_val;

  logic [30:0]        sq_r;
  logic               sq_v_r, sq_first_r, sq_last_r;
  logic [ACC_W-1:0]   acc_r;
  logic               fin_r;
  logic               hold_r;
  result_t            held_r;
  logic [15:0]        first_abs_r;
  logic signed [22:0] reward;

  always_comb begin
    sel_tag = '0;
    sel_val = '0;
    for (int l = 0; l < LANES; l++) begin
      if (lane_tag[l].valid) begin
        sel_tag = lane_tag[l];
        sel_val = lane_val[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      fin_r  <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      sq_v_r <= sel_tag.valid;
      fin_r  <= sq_v_r && sq_last_r;
      if (sel_tag.valid && int'(sel_tag.dim) == NOUT - 1) begin
        hold_r <= 1'b1;
      end else if (fin_r) begin
        hold_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r       <= 31'(sel_val * sel_val);
    sq_first_r <= (sel_tag.dim == 6'd0);
    sq_last_r  <= (int'(sel_tag.dim) == OBS_DIM - 1);
    if (sq_v_r) begin
      if (sq_first_r) begin
        acc_r <= ACC_W'(sq_r >> 12);
      end else begin
        acc_r <= acc_r + ACC_W'(sq_r >> 12);
      end
    end
    if (sel_tag.valid && sel_tag.dim == 6'd0) begin
      first_abs_r <= sel_val[15] ? 16'(-{sel_val[15], sel_val}) : 16'(sel_val);
    end
    if (sel_tag.valid && int'(sel_tag.dim) == NOUT - 1) begin
      held_r.env    <= sel_tag.env;
      held_r.dim    <= sel_tag.dim[3:0];
      held_r.state  <= sel_val;
      held_r.reward <= '0;
      held_r.done   <= 1'b0;
      held_r.last   <= 1'b1;
    end
  end

  always_comb begin
    if (acc_r > COST_MAX) begin
      reward = REWARD_MIN;
    end else begin
      reward = 23'(ACC_W'(0) - acc_r);
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (fin_r) begin
      push             = 1'b1;
      push_data        = held_r;
      push_data.reward = reward;
      push_data.done   = first_abs_r > {1'b0, limit};
    end else if (sel_tag.valid && int'(sel_tag.dim) < NOUT - 1) begin
      push            = 1'b1;
      push_data.env   = sel_tag.env;
      push_data.dim   = sel_tag.dim[3:0];
      push_data.state = sel_val;
    end else if (ack_push) begin
      // reset acknowledge beat
      push           = 1'b1;
      push_data.last = 1'b1;
    end
  end

  assign stat.fin  = fin_r;
  assign stat.hold = hold_r;
  assign stat.take = sel_tag.valid;

endmodule
`default_nettype wire

// ===== rtl/core/lenv_ofifo.sv =====
// lenv_ofifo: small result queue in front of the output channel.
// Depends on lenv_pkg.
`default_nettype none
module lenv_ofifo #(
  parameter int DEPTH = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire lenv_pkg::result_t push_data,
  input  wire                pop,
  output lenv_pkg::result_t  head,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);
  import lenv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         q [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (int'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp_r] <= push_data;
    end
  end

  assign head = q[rp_r];
  assign cnt  = cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/linear_env_step_with_hash_reset_unit.sv =====
// linear_env_step_with_hash_reset_unit: top level, sequencer, lanes, merge
// and result queue. Depends on lenv_pkg, lenv_lane, lenv_merge, lenv_ofifo.
//
//  channel | dir | beat contents
//  in_     | in  | opcode, env index, seed, eight actions
//  out_    | out | env, dim, state, reward, done, last
//  cfg_    | in  | register index, write data
//
// a step issues its OBS_DIM dims, one a cycle while queue credit lasts, via
// the lane owning each; results leave one beat a cycle if out_ready is high
// in a reset beat all lanes hash and write their banks in parallel, one row
// per cycle
// reset clears control only; state is undefined until a reset beat
// out_ready low stalls dim issue once the result queue credit runs out
`default_nettype none
module linear_env_step_with_hash_reset_unit #(
  parameter int ENV_COUNT = lenv_pkg::ENV_COUNT_DEF,
  parameter int OBS_DIM   = lenv_pkg::OBS_DIM_DEF,
  parameter int ACT_DIM   = lenv_pkg::ACT_DIM_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [0:0]        in_opcode,
  input  wire  [5:0]        in_env_index,
  input  wire  [31:0]       in_seed_value,
  input  wire  signed [15:0] in_action_0,
  input  wire  signed [15:0] in_action_1,
  input  wire  signed [15:0] in_action_2,
  input  wire  signed [15:0] in_action_3,
  input  wire  signed [15:0] in_action_4,
  input  wire  signed [15:0] in_action_5,
  input  wire  signed [15:0] in_action_6,
  input  wire  signed [15:0] in_action_7,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [5:0]        out_env,
  output logic [3:0]        out_dim,
  output logic signed [15:0] out_state_value,
  output logic signed [22:0] out_reward_value,
  output logic              out_done_flag,
  output logic              out_last_flag,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [1:0]        cfg_index,
  input  wire  [15:0]       cfg_data
);
  import lenv_pkg::*;

  localparam int DPL = (OBS_DIM + LANES - 1) / LANES;
  localparam int BD  = ENV_COUNT * DPL;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int EW  = (ENV_COUNT > 1) ? $clog2(ENV_COUNT) : 1;
  localparam int DW  = (OBS_DIM > 1) ? $clog2(OBS_DIM) : 1;
  localparam int GW  = (DPL > 1) ? $clog2(DPL) : 1;
  localparam int CW  = $clog2(OFIFO_DEPTH + 1);
  localparam logic [31:0] GRP_STEP = 32'(LANES) * C_DIM;

  seq_state_t state_r, state_nxt;

  logic signed [15:0] decay_r, force_r;
  logic [14:0]        limit_r;

  logic [EW-1:0]      env_r;
  logic [DW-1:0]      dim_r;
  logic signed [15:0] act_r [8];
  logic [31:0]        seed_r;
  logic [EW-1:0]      henv_r;
  logic [GW-1:0]      hgrp_r;
  logic [AW-1:0]      haddr_r;
  logic [31:0]        envmul_r, gmul_r;
  logic [1:0]         drain_r;
  logic [3:0]         infl_r;

  logic               in_fire, credit_ok;
  logic               step_issue, hash_issue, ack_push;
  logic [AW-1:0]      step_addr;
  logic signed [15:0] act_sel;

  step_tag_t          lane_tag [LANES];
  logic signed [15:0] lane_val [LANES];

  logic               push;
  result_t            push_data, head;
  merge_stat_t        mstat;
  logic [CW-1:0]      fifo_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= 16'sd4055;
      force_r <= 16'sd410;
      limit_r <= 15'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DECAY: decay_r <= $signed(cfg_data);
        CFG_FORCE: force_r <= $signed(cfg_data);
        CFG_LIMIT: limit_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign in_fire   = in_valid && in_ready;
  assign credit_ok = (int'(fifo_cnt) + int'(infl_r) + int'(mstat.hold)) < OFIFO_DEPTH - 1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_RESET) begin
            state_nxt = ST_HASH;
          end else if (int'(in_env_index) < ENV_COUNT) begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (credit_ok && int'(dim_r) == OBS_DIM - 1) begin
          state_nxt = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        if (mstat.fin) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HASH: begin
        if (int'(hgrp_r) == DPL - 1 && int'(henv_r) == ENV_COUNT - 1) begin
          state_nxt = ST_HASH_WAIT;
        end
      end
      ST_HASH_WAIT: begin
        if (drain_r == 2'd0 && int'(fifo_cnt) < OFIFO_DEPTH) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    step_issue = 1'b0;
    hash_issue = 1'b0;
    ack_push   = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready   = 1'b1;
      ST_STEP:      step_issue = credit_ok;
      ST_HASH:      hash_issue = 1'b1;
      ST_HASH_WAIT: ack_push   = (drain_r == 2'd0) && (int'(fifo_cnt) < OFIFO_DEPTH);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      infl_r  <= '0;
    end else begin
      state_r <= state_nxt;
      infl_r  <= infl_r + 4'(step_issue) - 4'(mstat.take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      env_r    <= EW'(in_env_index);
      dim_r    <= '0;
      act_r[0] <= in_action_0;
      act_r[1] <= in_action_1;
      act_r[2] <= in_action_2;
      act_r[3] <= in_action_3;
      act_r[4] <= in_action_4;
      act_r[5] <= in_action_5;
      act_r[6] <= in_action_6;
      act_r[7] <= in_action_7;
      seed_r   <= in_seed_value;
      henv_r   <= '0;
      hgrp_r   <= '0;
      haddr_r  <= '0;
      envmul_r <= '0;
      gmul_r   <= '0;
    end
    if (step_issue && int'(dim_r) != OBS_DIM - 1) begin
      dim_r <= dim_r + 1'b1;
    end
    if (hash_issue) begin
      haddr_r <= haddr_r + 1'b1;
      if (int'(hgrp_r) == DPL - 1) begin
        hgrp_r   <= '0;
        gmul_r   <= '0;
        henv_r   <= henv_r + 1'b1;
        envmul_r <= envmul_r + C_ENV;
      end else begin
        hgrp_r <= hgrp_r + 1'b1;
        gmul_r <= gmul_r + GRP_STEP;
      end
    end
    if (state_r == ST_HASH) begin
      drain_r <= 2'd3;
    end else if (drain_r != 2'd0) begin
      drain_r <= drain_r - 1'b1;
    end
  end

  assign step_addr = AW'(int'(env_r) * DPL + int'(dim_r) / LANES);

  always_comb begin
    act_sel = act_r[ACT_DIM-1];
    for (int k = 0; k < ACT_DIM - 1; k++) begin
      if (int'(dim_r) == k) begin
        act_sel = act_r[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    step_tag_t lane_issue;
    logic      lane_hash;

    always_comb begin
      lane_issue.valid = step_issue && ((int'(dim_r) % LANES) == l);
      lane_issue.dim   = 6'(dim_r);
      lane_issue.env   = 6'(env_r);
    end
    assign lane_hash = hash_issue && (int'(hgrp_r) * LANES + l < OBS_DIM);

    lenv_lane #(
      .ENV_COUNT(ENV_COUNT),
      .DPL      (DPL),
      .LANE     (l),
      .AW       (AW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .issue    (lane_issue),
      .rd_addr  (step_addr),
      .act      (act_sel),
      .decay    (decay_r),
      .force_k  (force_r),
      .hash_en  (lane_hash),
      .hash_addr(haddr_r),
      .seed_env (seed_r ^ envmul_r),
      .grp_mul  (gmul_r),
      .res_tag  (lane_tag[l]),
      .res_val  (lane_val[l])
    );
  end

  lenv_merge #(
    .OBS_DIM(OBS_DIM)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .lane_tag (lane_tag),
    .lane_val (lane_val),
    .limit    (limit_r),
    .ack_push (ack_push),
    .push     (push),
    .push_data(push_data),
    .stat     (mstat)
  );

  lenv_ofifo #(
    .DEPTH(OFIFO_DEPTH)
  ) u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (out_valid && out_ready),
    .head     (head),
    .cnt      (fifo_cnt)
  );

  assign out_valid        = (fifo_cnt != '0);
  assign out_env          = head.env;
  assign out_dim          = head.dim;
  assign out_state_value  = head.state;
  assign out_reward_value = head.reward;
  assign out_done_flag    = head.done;
  assign out_last_flag    = head.last;

  logic [LANES-1:0] lane_valid_vec;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_valid_vec[l] = lane_tag[l].valid;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fifo_cnt) <= OFIFO_DEPTH)
    else $error("result queue overfilled");

  a_one_lane: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lane_valid_vec))
    else $error("two lanes finished a step dim together");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (infl_r == 4'd0 && !mstat.hold))
    else $error("new beat taken with dims still in flight");

endmodule
`default_nettype wire
